>>> design/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg - shared types and constants for the script lexer
// Token codes, scan modes, character codes, the keyword table and helpers
// used by the lexer core and the keyword matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

  // Output field width of offsets and line numbers
  typedef logic [15:0] lex_t;
  typedef logic [5:0]  kind_t;

  // Scan modes
  typedef enum logic [2:0] {
    MD_IDLE,
    MD_OP,
    MD_COMMENT,
    MD_STRING,
    MD_INT,
    MD_DOT,
    MD_FRAC,
    MD_WORD
  } scan_mode_t;

  // Error codes
  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_UNEXPECTED = 2'd1,
    ERR_UNTERM     = 2'd2
  } err_t;

  // Token kinds
  localparam kind_t TK_LPAREN  = 6'd0;
  localparam kind_t TK_RPAREN  = 6'd1;
  localparam kind_t TK_LBRACE  = 6'd2;
  localparam kind_t TK_RBRACE  = 6'd3;
  localparam kind_t TK_COMMA   = 6'd4;
  localparam kind_t TK_DOT     = 6'd5;
  localparam kind_t TK_MINUS   = 6'd6;
  localparam kind_t TK_PLUS    = 6'd7;
  localparam kind_t TK_SEMI    = 6'd8;
  localparam kind_t TK_SLASH   = 6'd9;
  localparam kind_t TK_STAR    = 6'd10;
  localparam kind_t TK_BANG    = 6'd11;
  localparam kind_t TK_BANG_EQ = 6'd12;
  localparam kind_t TK_EQ      = 6'd13;
  localparam kind_t TK_EQ_EQ   = 6'd14;
  localparam kind_t TK_GT      = 6'd15;
  localparam kind_t TK_GT_EQ   = 6'd16;
  localparam kind_t TK_LT      = 6'd17;
  localparam kind_t TK_LT_EQ   = 6'd18;
  localparam kind_t TK_IDENT   = 6'd19;
  localparam kind_t TK_STRING  = 6'd20;
  localparam kind_t TK_NUMBER  = 6'd21;
  localparam kind_t TK_AND     = 6'd22;
  localparam kind_t TK_EOF     = 6'd38;
  localparam kind_t TK_ERROR   = 6'd39;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keyword table: text left-justified in six characters, padded with spaces
  localparam int KW_COUNT = 16;
  localparam int KW_MAX   = 6;
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    "and   ", "class ", "else  ", "false ", "fun   ", "for   ", "if    ", "nil   ",
    "or    ", "print ", "return", "super ", "this  ", "true  ", "var   ", "while "
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
    3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
  };

  // One result word
  typedef struct packed {
    kind_t kind;
    err_t  err;
    lex_t  lstart;
    lex_t  lend;
    lex_t  line;
  } tok_res_t;

  function automatic tok_res_t mk_res(input kind_t kind, input lex_t lstart,
                                      input lex_t lend, input lex_t line,
                                      input err_t err);
    tok_res_t r;
    r.kind   = kind;
    r.err    = err;
    r.lstart = lstart;
    r.lend   = lend;
    r.line   = line;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
  endfunction

  // Operator kind from the held first character
  function automatic kind_t op_kind(input logic [7:0] op, input logic two);
    kind_t k;
    case (op)
      CH_BANG: k = two ? TK_BANG_EQ : TK_BANG;
      CH_EQ:   k = two ? TK_EQ_EQ   : TK_EQ;
      CH_GT:   k = two ? TK_GT_EQ   : TK_GT;
      CH_LT:   k = two ? TK_LT_EQ   : TK_LT;
      default: k = TK_SLASH;
    endcase
    return k;
  endfunction

  function automatic lex_t line_inc(input lex_t l);
    return (l == 16'hFFFF) ? l : l + 16'd1;
  endfunction

endpackage

`default_nettype wire

>>> design/slt_kwmatch.sv
// ----------------------------------------------------------------------------
// slt_kwmatch - keyword matcher
// Compares a buffered word against the sixteen keywords in parallel and
// returns the keyword kind, or the identifier kind when nothing matches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slt_kwmatch #(
  parameter int KEYWORD_CHARS = 6
) (
  input  wire logic [KEYWORD_CHARS*8-1:0]         kw_buf,  // char i in bits [8i+7:8i]
  input  wire logic [$clog2(KEYWORD_CHARS+2)-1:0] kw_len,
  output logic [5:0]                              kw_kind
);

  localparam int LW = $clog2(KEYWORD_CHARS + 2);

  logic [slt_pkg::KW_COUNT-1:0] hit;

  // Compare every keyword, only over its own length
  always_comb begin
    for (int k = 0; k < slt_pkg::KW_COUNT; k++) begin
      hit[k] = (kw_len == LW'(slt_pkg::KW_LEN[k]));
      for (int i = 0; i < slt_pkg::KW_MAX; i++) begin
        if (i < int'(slt_pkg::KW_LEN[k])) begin
          hit[k] = hit[k] &&
                   (kw_buf[8*i +: 8] == slt_pkg::KW_TEXT[k][8*(slt_pkg::KW_MAX-1-i) +: 8]);
        end
      end
    end
  end

  // Keywords are distinct, so at most one hit
  always_comb begin
    kw_kind = slt_pkg::TK_IDENT;
    for (int k = 0; k < slt_pkg::KW_COUNT; k++) begin
      if (hit[k]) begin
        kw_kind = slt_pkg::TK_AND + 6'(k);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/script_lexer_tokenizer.sv
// ----------------------------------------------------------------------------
// script_lexer_tokenizer - streaming source lexer
// Scans one source character per word and emits tokens as they complete,
// with offsets, line number and error reports.
// ----------------------------------------------------------------------------
// Results: the first result of a character appears in the cycle after it is taken.
// Throughput: one character per cycle while each yields at most one result and the
// receiver is ready; a character yielding more than one result (up to four) holds the
// result register until all have drained, one result word per cycle while the receiver is ready.
// Reset: clears scan state, offset to zero, line to one; the result register
// empties. An end-of-source word also returns the state to these values.
`timescale 1ns / 1ps
`default_nettype none

module script_lexer_tokenizer #(
  parameter int OFFSET_BITS   = 16,
  parameter int KEYWORD_CHARS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // source characters
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic [0:0]  in_tuser,   // [0] char_valid
  input  wire logic        in_tlast,   // is_last
  // tokens
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [15:0] lexeme_start, [31:16] lexeme_end,
                                       // [47:32] line_number
  output logic [7:0]       out_tuser,  // [5:0] token_kind, [7:6] error_code
  output logic             out_tlast   // last_of_run
);

  localparam int LW = $clog2(KEYWORD_CHARS + 2);
  localparam int KB = KEYWORD_CHARS * 8;

  typedef logic [OFFSET_BITS-1:0] off_t;

  // Scan state
  slt_pkg::scan_mode_t mode_r, mode_nxt;
  logic [7:0]          pend_r, pend_nxt;
  off_t                tstart_r, tstart_nxt;
  off_t                offset_r, offset_nxt;
  slt_pkg::lex_t       line_r, line_nxt;
  logic [LW-1:0]       wlen_r, wlen_nxt;
  logic [KB-1:0]       kb_r;

  // Result register
  slt_pkg::tok_res_t   bund_r [4];
  logic [2:0]          bcnt_r;
  logic [1:0]          bidx_r;
  logic                bvalid_r;

  slt_pkg::tok_res_t   res_v [4];
  logic [2:0]          n_v;
  logic                kb_start, kb_cont, do_idle;
  logic                in_fire, out_fire, out_last;
  logic [7:0]          c;
  off_t                p, p1, pb, q, qb;
  logic [KB-1:0]       kb_app;
  logic [LW-1:0]       wlen_app;
  slt_pkg::kind_t      kind_cur, kind_app;
  slt_pkg::tok_res_t   cur;

  function automatic slt_pkg::kind_t punct_kind(input logic [7:0] ch);
    slt_pkg::kind_t k;
    case (ch)
      slt_pkg::CH_LPAREN: k = slt_pkg::TK_LPAREN;
      slt_pkg::CH_RPAREN: k = slt_pkg::TK_RPAREN;
      slt_pkg::CH_LBRACE: k = slt_pkg::TK_LBRACE;
      slt_pkg::CH_RBRACE: k = slt_pkg::TK_RBRACE;
      slt_pkg::CH_COMMA:  k = slt_pkg::TK_COMMA;
      slt_pkg::CH_DOT:    k = slt_pkg::TK_DOT;
      slt_pkg::CH_MINUS:  k = slt_pkg::TK_MINUS;
      slt_pkg::CH_PLUS:   k = slt_pkg::TK_PLUS;
      slt_pkg::CH_SEMI:   k = slt_pkg::TK_SEMI;
      default:            k = slt_pkg::TK_STAR;
    endcase
    return k;
  endfunction

  assign c        = in_tdata;
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign out_last = ({1'b0, bidx_r} == (bcnt_r - 3'd1));
  assign in_tready = !bvalid_r || (out_tready && out_last);

  // Saturating offset neighbours of the current offset
  assign p  = offset_r;
  assign p1 = (p == '1) ? p : p + off_t'(1);
  assign pb = (p == '0) ? p : p - off_t'(1);

  // Word buffer with this character appended
  always_comb begin
    kb_app = kb_r;
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (wlen_r == LW'(i)) begin
        kb_app[8*i +: 8] = c;
      end
    end
    wlen_app = (wlen_r <= LW'(KEYWORD_CHARS)) ? wlen_r + LW'(1) : wlen_r;
  end

  slt_kwmatch #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_kw_cur (
    .kw_buf  (kb_r),
    .kw_len  (wlen_r),
    .kw_kind (kind_cur)
  );

  slt_kwmatch #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_kw_app (
    .kw_buf  (kb_app),
    .kw_len  (wlen_app),
    .kw_kind (kind_app)
  );

  // Scan one word: continue the current token, rescan as new, then flush on end
  always_comb begin
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    tstart_nxt = tstart_r;
    offset_nxt = offset_r;
    line_nxt   = line_r;
    wlen_nxt   = wlen_r;
    kb_start   = 1'b0;
    kb_cont    = 1'b0;
    do_idle    = 1'b0;
    n_v        = 3'd0;
    q          = '0;
    qb         = '0;
    for (int i = 0; i < 4; i++) begin
      res_v[i] = '0;
    end

    if (in_tuser[0]) begin
      case (mode_r)
        slt_pkg::MD_OP: begin
          mode_nxt = slt_pkg::MD_IDLE;
          if (pend_r == slt_pkg::CH_SLASH && c == slt_pkg::CH_SLASH) begin
            mode_nxt = slt_pkg::MD_COMMENT;
          end else if (pend_r != slt_pkg::CH_SLASH && c == slt_pkg::CH_EQ) begin
            res_v[n_v[1:0]] = slt_pkg::mk_res(slt_pkg::op_kind(pend_r, 1'b1),
                slt_pkg::lex_t'(tstart_r), slt_pkg::lex_t'(p1), line_nxt, slt_pkg::ERR_NONE);
            n_v = n_v + 3'd1;
          end else begin
            res_v[n_v[1:0]] = slt_pkg::mk_res(slt_pkg::op_kind(pend_r, 1'b0),
                slt_pkg::lex_t'(tstart_r), slt_pkg::lex_t'(p), line_nxt, slt_pkg::ERR_NONE);
            n_v = n_v + 3'd1;
            do_idle = 1'b1;
          end
        end
        slt_pkg::MD_COMMENT: begin
          if (c == slt_pkg::CH_NL) begin
            mode_nxt = slt_pkg::MD_IDLE;
            do_idle  = 1'b1;
          end
        end
        slt_pkg::MD_STRING: begin
          if (c == slt_pkg::CH_QUOTE) begin
            res_v[n_v[1:0]] = slt_pkg::mk_res(slt_pkg::TK_STRING,
                slt_pkg::lex_t'((tstart_r == '1) ? tstart_r : tstart_r + off_t'(1)),
                slt_pkg::lex_t'(p), line_nxt, slt_pkg::ERR_NONE);
            n_v = n_v + 3'd1;
            mode_nxt = slt_pkg::MD_IDLE;
          end else if (c == slt_pkg::CH_NL) begin
            line_nxt = slt_pkg::line_inc(line_r);
          end
        end
        slt_pkg::MD_INT: begin
          if (c == slt_pkg::CH_DOT) begin
            mode_nxt = slt_pkg::MD_DOT;
          end else if (!slt_pkg::is_digit(c)) begin
            res_v[n_v[1:0]] = slt_pkg::mk_res(slt_pkg::TK_NUMBER,
                slt_pkg::lex_t'(tstart_r), slt_pkg::lex_t'(p), line_nxt, slt_pkg::ERR_NONE);
            n_v = n_v + 3'd1;
            mode_nxt = slt_pkg::MD_IDLE;
            do_idle  = 1'b1;
          end
        end
        slt_pkg::MD_DOT: begin
          if (slt_pkg::is_digit(c)) begin
            mode_nxt = slt_pkg::MD_FRAC;
          end else begin
            // number ends before the held dot, then the dot itself
            res_v[n_v[1:0]] = slt_pkg::mk_res(slt_pkg::TK_NUMBER,
                slt_pkg::lex_t'(tstart_r), slt_pkg::lex_t'(pb), line_nxt, slt_pkg::ERR_NONE);
            n_v = n_v + 3'd1;
            res_v[n_v[1:0]] = slt_pkg::mk_res(slt_pkg::TK_DOT,
                slt_pkg::lex_t'(pb), slt_pkg::lex_t'(p), line_nxt, slt_pkg::ERR_NONE);
            n_v = n_v + 3'd1;
            mode_nxt = slt_pkg::MD_IDLE;
            do_idle  = 1'b1;
          end
        end
        slt_pkg::MD_FRAC: begin
          if (!slt_pkg::is_digit(c)) begin
            res_v[n_v[1:0]] = slt_pkg::mk_res(slt_pkg::TK_NUMBER,
                slt_pkg::lex_t'(tstart_r), slt_pkg::lex_t'(p), line_nxt, slt_pkg::ERR_NONE);
            n_v = n_v + 3'd1;
            mode_nxt = slt_pkg::MD_IDLE;
            do_idle  = 1'b1;
          end
        end
        slt_pkg::MD_WORD: begin
          if (slt_pkg::is_alpha(c) || slt_pkg::is_digit(c)) begin
            kb_cont  = 1'b1;
            wlen_nxt = wlen_app;
          end else begin
            res_v[n_v[1:0]] = slt_pkg::mk_res(kind_cur,
                slt_pkg::lex_t'(tstart_r), slt_pkg::lex_t'(p), line_nxt, slt_pkg::ERR_NONE);
            n_v = n_v + 3'd1;
            mode_nxt = slt_pkg::MD_IDLE;
            do_idle  = 1'b1;
          end
        end
        default: begin
          mode_nxt = slt_pkg::MD_IDLE;
          do_idle  = 1'b1;
        end
      endcase

      // Scan the character as the start of a new token
      if (do_idle) begin
        tstart_nxt = p;
        case (c)
          slt_pkg::CH_LPAREN, slt_pkg::CH_RPAREN, slt_pkg::CH_LBRACE,
          slt_pkg::CH_RBRACE, slt_pkg::CH_COMMA, slt_pkg::CH_DOT,
          slt_pkg::CH_MINUS, slt_pkg::CH_PLUS, slt_pkg::CH_SEMI,
          slt_pkg::CH_STAR: begin
            res_v[n_v[1:0]] = slt_pkg::mk_res(punct_kind(c),
                slt_pkg::lex_t'(p), slt_pkg::lex_t'(p1), line_nxt, slt_pkg::ERR_NONE);
            n_v = n_v + 3'd1;
          end
          slt_pkg::CH_BANG, slt_pkg::CH_EQ, slt_pkg::CH_LT, slt_pkg::CH_GT,
          slt_pkg::CH_SLASH: begin
            mode_nxt = slt_pkg::MD_OP;
            pend_nxt = c;
          end
          slt_pkg::CH_SPACE, slt_pkg::CH_CR, slt_pkg::CH_TAB: begin
          end
          slt_pkg::CH_NL: begin
            line_nxt = slt_pkg::line_inc(line_r);
          end
          slt_pkg::CH_QUOTE: begin
            mode_nxt = slt_pkg::MD_STRING;
          end
          default: begin
            if (slt_pkg::is_digit(c)) begin
              mode_nxt = slt_pkg::MD_INT;
            end else if (slt_pkg::is_alpha(c)) begin
              mode_nxt = slt_pkg::MD_WORD;
              kb_start = 1'b1;
              wlen_nxt = LW'(1);
            end else begin
              res_v[n_v[1:0]] = slt_pkg::mk_res(slt_pkg::TK_ERROR,
                  slt_pkg::lex_t'(p), slt_pkg::lex_t'(p1), line_nxt,
                  slt_pkg::ERR_UNEXPECTED);
              n_v = n_v + 3'd1;
            end
          end
        endcase
      end
      offset_nxt = p1;
    end

    // End of source: flush the pending token, then end-of-file
    if (in_tlast) begin
      q  = offset_nxt;
      qb = (q == '0) ? q : q - off_t'(1);
      case (mode_nxt)
        slt_pkg::MD_OP: begin
          res_v[n_v[1:0]] = slt_pkg::mk_res(slt_pkg::op_kind(pend_nxt, 1'b0),
              slt_pkg::lex_t'(tstart_nxt), slt_pkg::lex_t'(q), line_nxt, slt_pkg::ERR_NONE);
          n_v = n_v + 3'd1;
        end
        slt_pkg::MD_STRING: begin
          res_v[n_v[1:0]] = slt_pkg::mk_res(slt_pkg::TK_ERROR,
              slt_pkg::lex_t'(tstart_nxt), slt_pkg::lex_t'(q), line_nxt, slt_pkg::ERR_UNTERM);
          n_v = n_v + 3'd1;
        end
        slt_pkg::MD_INT, slt_pkg::MD_FRAC: begin
          res_v[n_v[1:0]] = slt_pkg::mk_res(slt_pkg::TK_NUMBER,
              slt_pkg::lex_t'(tstart_nxt), slt_pkg::lex_t'(q), line_nxt, slt_pkg::ERR_NONE);
          n_v = n_v + 3'd1;
        end
        slt_pkg::MD_DOT: begin
          res_v[n_v[1:0]] = slt_pkg::mk_res(slt_pkg::TK_NUMBER,
              slt_pkg::lex_t'(tstart_nxt), slt_pkg::lex_t'(qb), line_nxt, slt_pkg::ERR_NONE);
          n_v = n_v + 3'd1;
          res_v[n_v[1:0]] = slt_pkg::mk_res(slt_pkg::TK_DOT,
              slt_pkg::lex_t'(qb), slt_pkg::lex_t'(q), line_nxt, slt_pkg::ERR_NONE);
          n_v = n_v + 3'd1;
        end
        slt_pkg::MD_WORD: begin
          // a word begun on this character is one letter long: never a keyword
          res_v[n_v[1:0]] = slt_pkg::mk_res(
              !in_tuser[0] ? kind_cur : (kb_cont ? kind_app : slt_pkg::TK_IDENT),
              slt_pkg::lex_t'(tstart_nxt), slt_pkg::lex_t'(q), line_nxt, slt_pkg::ERR_NONE);
          n_v = n_v + 3'd1;
        end
        default: begin
        end
      endcase
      res_v[n_v[1:0]] = slt_pkg::mk_res(slt_pkg::TK_EOF,
          slt_pkg::lex_t'(q), slt_pkg::lex_t'(q), line_nxt, slt_pkg::ERR_NONE);
      n_v = n_v + 3'd1;
    end
  end

  // Commit scan state on each accepted word; end of source restarts it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= slt_pkg::MD_IDLE;
      pend_r   <= '0;
      tstart_r <= '0;
      offset_r <= '0;
      line_r   <= 16'd1;
      wlen_r   <= '0;
    end else if (in_fire) begin
      if (in_tlast) begin
        mode_r   <= slt_pkg::MD_IDLE;
        pend_r   <= '0;
        tstart_r <= '0;
        offset_r <= '0;
        line_r   <= 16'd1;
        wlen_r   <= '0;
      end else begin
        mode_r   <= mode_nxt;
        pend_r   <= pend_nxt;
        tstart_r <= tstart_nxt;
        offset_r <= offset_nxt;
        line_r   <= line_nxt;
        wlen_r   <= wlen_nxt;
      end
    end
  end

  // Word buffer: a new word writes only its first byte; bytes past its length keep older contents
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (kb_cont) begin
        kb_r <= kb_app;
      end else if (kb_start) begin
        kb_r[7:0] <= c;
      end
    end
  end

  // Result register: load the results of a word, otherwise drain one per cycle while the receiver is ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= 1'b0;
      bidx_r   <= '0;
      bcnt_r   <= '0;
    end else if (in_fire && n_v != 3'd0) begin
      bvalid_r <= 1'b1;
      bidx_r   <= '0;
      bcnt_r   <= n_v;
    end else if (out_fire) begin
      if (out_last) begin
        bvalid_r <= 1'b0;
        bidx_r   <= '0;
      end else begin
        bidx_r <= bidx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && n_v != 3'd0) begin
      for (int i = 0; i < 4; i++) begin
        bund_r[i] <= res_v[i];
      end
    end
  end

  // Present the current result word
  assign cur        = bund_r[bidx_r];
  assign out_tvalid = bvalid_r;
  assign out_tdata  = {cur.line, cur.lend, cur.lstart};
  assign out_tuser  = {cur.err, cur.kind};
  assign out_tlast  = out_last;

  // Checks
  a_bund_idx: assert property (@(posedge clk) disable iff (!rst_n)
    bvalid_r |-> (bcnt_r != 3'd0 && {1'b0, bidx_r} < bcnt_r))
    else $error("result index beyond loaded count");

  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (mode_r == slt_pkg::MD_IDLE && offset_r == '0 &&
                               line_r == 16'd1))
    else $error("scan state not restarted after end of source");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != 16'd0)
    else $error("line counter reached zero");

  a_word_len: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == slt_pkg::MD_WORD) |-> (wlen_r != '0))
    else $error("word mode with empty word");

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench for script_lexer_tokenizer
// Streams source characters into the lexer and checks every token word that
// comes out against a cycle-free model of the scanner kept in this bench.
// A short directed table opens the run. Random sources built from tokens,
// broken fragments and noise follow under changing back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT_NS  = 400_000;
  localparam int MAX_SHOWN = 10;

  // character pools for random sources
  localparam string NAME_CHARS =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  localparam string PUNCT      = "(){},.-+;*";
  localparam string OPS        = "!=<>/";
  localparam string SPACES     = " \t\r\n";
  localparam string SEPARATORS = " ();\n";

  // keyword spellings right-justified, as a word is shifted in;
  // position in the list gives the kind offset from TK_AND
  localparam logic [47:0] RESERVED_WORDS [16] = '{
    "and", "class", "else", "false", "fun", "for", "if", "nil",
    "or", "print", "return", "super", "this", "true", "var", "while"
  };

  typedef struct packed {
    slt_pkg::kind_t kind;
    slt_pkg::err_t  err;
    slt_pkg::lex_t  lstart;
    slt_pkg::lex_t  lend;
    slt_pkg::lex_t  line;
    logic           last;
  } tok_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       cv;
    logic       lst;
    logic       typed;
    tok_t       tok;
  } stim_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  wire         in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic [0:0]  in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [47:0] out_tdata;
  wire  [7:0]  out_tuser;
  wire         out_tlast;

  int src_idle  = 33;
  int rcv_idle  = 64;
  int bad_count = 0;
  int items_sent = 0;

  // scanner model state
  slt_pkg::scan_mode_t scan_st;
  logic [7:0]          held_op;
  slt_pkg::lex_t       tok_begin;
  slt_pkg::lex_t       src_pos;
  slt_pkg::lex_t       line_no;
  logic [47:0]         word_bits;
  int                  word_len;

  tok_t       step_toks[$];
  tok_t       tokens_due[$];
  logic [7:0] src_bytes[$];
  stim_row_t  dir_rows[26];

  script_lexer_tokenizer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Scanner model
  function automatic slt_pkg::lex_t pos_after(input slt_pkg::lex_t p);
    return (p == 16'hFFFF) ? p : p + 16'd1;
  endfunction

  function automatic slt_pkg::lex_t pos_prior(input slt_pkg::lex_t p);
    return (p == 16'd0) ? p : p - 16'd1;
  endfunction

  function automatic bit digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit name_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic slt_pkg::kind_t pair_kind(input logic [7:0] op, input bit two);
    case (op)
      slt_pkg::CH_BANG: return two ? slt_pkg::TK_BANG_EQ : slt_pkg::TK_BANG;
      slt_pkg::CH_EQ:   return two ? slt_pkg::TK_EQ_EQ   : slt_pkg::TK_EQ;
      slt_pkg::CH_GT:   return two ? slt_pkg::TK_GT_EQ   : slt_pkg::TK_GT;
      slt_pkg::CH_LT:   return two ? slt_pkg::TK_LT_EQ   : slt_pkg::TK_LT;
      default:          return slt_pkg::TK_SLASH;
    endcase
  endfunction

  function void clear_scan();
    scan_st   = slt_pkg::MD_IDLE;
    held_op   = 8'd0;
    tok_begin = 16'd0;
    src_pos   = 16'd0;
    line_no   = 16'd1;
    word_bits = 48'd0;
    word_len  = 0;
  endfunction

  function void add_tok(input slt_pkg::kind_t k, input slt_pkg::lex_t s,
                        input slt_pkg::lex_t e, input slt_pkg::err_t er);
    tok_t t;
    if (step_toks.size() >= 4) return;
    t.kind   = k;
    t.err    = er;
    t.lstart = s;
    t.lend   = e;
    t.line   = line_no;
    t.last   = 1'b0;
    step_toks.push_back(t);
  endfunction

  // Long words never match; short ones are compared whole
  function slt_pkg::kind_t word_kind();
    if (word_len > slt_pkg::KW_MAX) return slt_pkg::TK_IDENT;
    for (int i = 0; i < 16; i++)
      if (word_bits == RESERVED_WORDS[i]) return slt_pkg::TK_AND + slt_pkg::kind_t'(i);
    return slt_pkg::TK_IDENT;
  endfunction

  // Start a new token from the idle state
  function void idle_scan(input logic [7:0] c);
    slt_pkg::kind_t k;
    tok_begin = src_pos;
    case (c)
      slt_pkg::CH_LPAREN: k = slt_pkg::TK_LPAREN;
      slt_pkg::CH_RPAREN: k = slt_pkg::TK_RPAREN;
      slt_pkg::CH_LBRACE: k = slt_pkg::TK_LBRACE;
      slt_pkg::CH_RBRACE: k = slt_pkg::TK_RBRACE;
      slt_pkg::CH_COMMA:  k = slt_pkg::TK_COMMA;
      slt_pkg::CH_DOT:    k = slt_pkg::TK_DOT;
      slt_pkg::CH_MINUS:  k = slt_pkg::TK_MINUS;
      slt_pkg::CH_PLUS:   k = slt_pkg::TK_PLUS;
      slt_pkg::CH_SEMI:   k = slt_pkg::TK_SEMI;
      slt_pkg::CH_STAR:   k = slt_pkg::TK_STAR;
      slt_pkg::CH_BANG, slt_pkg::CH_EQ, slt_pkg::CH_LT, slt_pkg::CH_GT,
      slt_pkg::CH_SLASH: begin
        scan_st = slt_pkg::MD_OP;
        held_op = c;
        return;
      end
      slt_pkg::CH_SPACE, slt_pkg::CH_CR, slt_pkg::CH_TAB: return;
      slt_pkg::CH_NL: begin
        if (line_no != 16'hFFFF) line_no++;
        return;
      end
      slt_pkg::CH_QUOTE: begin
        scan_st = slt_pkg::MD_STRING;
        return;
      end
      default: begin
        if (digit_ch(c)) begin
          scan_st = slt_pkg::MD_INT;
        end else if (name_ch(c)) begin
          scan_st   = slt_pkg::MD_WORD;
          word_bits = {40'd0, c};
          word_len  = 1;
        end else begin
          add_tok(slt_pkg::TK_ERROR, src_pos, pos_after(src_pos), slt_pkg::ERR_UNEXPECTED);
        end
        return;
      end
    endcase
    add_tok(k, src_pos, pos_after(src_pos), slt_pkg::ERR_NONE);
  endfunction

  // Continue or close the token in progress, then rescan the character if it
  // was not absorbed
  function void char_scan(input logic [7:0] c);
    case (scan_st)
      slt_pkg::MD_OP: begin
        scan_st = slt_pkg::MD_IDLE;
        if (held_op == slt_pkg::CH_SLASH && c == slt_pkg::CH_SLASH) begin
          scan_st = slt_pkg::MD_COMMENT;
          return;
        end
        if (held_op != slt_pkg::CH_SLASH && c == slt_pkg::CH_EQ) begin
          add_tok(pair_kind(held_op, 1'b1), tok_begin, pos_after(src_pos),
                  slt_pkg::ERR_NONE);
          return;
        end
        add_tok(pair_kind(held_op, 1'b0), tok_begin, src_pos, slt_pkg::ERR_NONE);
      end
      slt_pkg::MD_COMMENT: begin
        if (c != slt_pkg::CH_NL) return;
        scan_st = slt_pkg::MD_IDLE;
      end
      slt_pkg::MD_STRING: begin
        if (c == slt_pkg::CH_QUOTE) begin
          add_tok(slt_pkg::TK_STRING, pos_after(tok_begin), src_pos, slt_pkg::ERR_NONE);
          scan_st = slt_pkg::MD_IDLE;
        end else if (c == slt_pkg::CH_NL && line_no != 16'hFFFF) begin
          line_no++;
        end
        return;
      end
      slt_pkg::MD_INT: begin
        if (digit_ch(c)) return;
        if (c == slt_pkg::CH_DOT) begin
          scan_st = slt_pkg::MD_DOT;
          return;
        end
        add_tok(slt_pkg::TK_NUMBER, tok_begin, src_pos, slt_pkg::ERR_NONE);
        scan_st = slt_pkg::MD_IDLE;
      end
      slt_pkg::MD_DOT: begin
        if (digit_ch(c)) begin
          scan_st = slt_pkg::MD_FRAC;
          return;
        end
        // held dot was not a fraction: number, then a dot token
        add_tok(slt_pkg::TK_NUMBER, tok_begin, pos_prior(src_pos), slt_pkg::ERR_NONE);
        add_tok(slt_pkg::TK_DOT, pos_prior(src_pos), src_pos, slt_pkg::ERR_NONE);
        scan_st = slt_pkg::MD_IDLE;
      end
      slt_pkg::MD_FRAC: begin
        if (digit_ch(c)) return;
        add_tok(slt_pkg::TK_NUMBER, tok_begin, src_pos, slt_pkg::ERR_NONE);
        scan_st = slt_pkg::MD_IDLE;
      end
      slt_pkg::MD_WORD: begin
        if (name_ch(c) || digit_ch(c)) begin
          if (word_len < slt_pkg::KW_MAX) word_bits = {word_bits[39:0], c};
          if (word_len <= slt_pkg::KW_MAX) word_len++;
          return;
        end
        add_tok(word_kind(), tok_begin, src_pos, slt_pkg::ERR_NONE);
        scan_st = slt_pkg::MD_IDLE;
      end
      default: scan_st = slt_pkg::MD_IDLE;
    endcase
    idle_scan(c);
  endfunction

  // Flush the pending token at end of source and add end-of-file
  function void end_scan();
    case (scan_st)
      slt_pkg::MD_OP:
        add_tok(pair_kind(held_op, 1'b0), tok_begin, src_pos, slt_pkg::ERR_NONE);
      slt_pkg::MD_STRING:
        add_tok(slt_pkg::TK_ERROR, tok_begin, src_pos, slt_pkg::ERR_UNTERM);
      slt_pkg::MD_INT, slt_pkg::MD_FRAC:
        add_tok(slt_pkg::TK_NUMBER, tok_begin, src_pos, slt_pkg::ERR_NONE);
      slt_pkg::MD_DOT: begin
        add_tok(slt_pkg::TK_NUMBER, tok_begin, pos_prior(src_pos), slt_pkg::ERR_NONE);
        add_tok(slt_pkg::TK_DOT, pos_prior(src_pos), src_pos, slt_pkg::ERR_NONE);
      end
      slt_pkg::MD_WORD:
        add_tok(word_kind(), tok_begin, src_pos, slt_pkg::ERR_NONE);
      default: ;
    endcase
    add_tok(slt_pkg::TK_EOF, src_pos, src_pos, slt_pkg::ERR_NONE);
  endfunction

  // Tokens caused by one input word, the final one marked last
  function void lex_step(input logic [7:0] c, input logic cv, input logic lst);
    step_toks.delete();
    if (cv) begin
      char_scan(c);
      src_pos = pos_after(src_pos);
    end
    if (lst) begin
      end_scan();
      clear_scan();
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
  endfunction

  // Drive one input word at the falling edge, hold it until taken, then
  // record what it should cause
  task automatic send_char(input stim_row_t r);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r.ch;
    in_tuser  <= r.cv;
    in_tlast  <= r.lst;
    do @(posedge clk); while (!in_tready);
    lex_step(r.ch, r.cv, r.lst);
    if (r.typed) tokens_due.push_back(r.tok);
    else foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
    if (r.cv || r.lst) items_sent++;
    @(negedge clk);
  endtask

  // Append one fragment of source text: mostly well-formed tokens, some
  // broken ones and raw noise
  function void add_fragment();
    int pick;
    logic [47:0] w;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 18) begin
      w = RESERVED_WORDS[$urandom_range(15)];
      for (int b = 5; b >= 0; b--)
        if (w[b*8 +: 8] != 8'd0) src_bytes.push_back(w[b*8 +: 8]);
      if ($urandom_range(3) == 0) src_bytes.push_back(NAME_CHARS[$urandom_range(62)]);
      if ($urandom_range(9) < 7) src_bytes.push_back(SEPARATORS[$urandom_range(4)]);
    end else if (pick < 30) begin
      src_bytes.push_back(NAME_CHARS[$urandom_range(52)]);
      repeat ($urandom_range(8)) src_bytes.push_back(NAME_CHARS[$urandom_range(62)]);
    end else if (pick < 44) begin
      repeat ($urandom_range(1, 4)) src_bytes.push_back(8'h30 + 8'($urandom_range(9)));
      if ($urandom_range(9) < 6) begin
        src_bytes.push_back(slt_pkg::CH_DOT);
        repeat ($urandom_range(3)) src_bytes.push_back(8'h30 + 8'($urandom_range(9)));
      end
    end else if (pick < 54) begin
      src_bytes.push_back(slt_pkg::CH_QUOTE);
      repeat ($urandom_range(5)) begin
        c = 8'($urandom_range(8'h20, 8'h7E));
        src_bytes.push_back((c == slt_pkg::CH_QUOTE) ? slt_pkg::CH_NL : c);
      end
      if ($urandom_range(19) < 17) src_bytes.push_back(slt_pkg::CH_QUOTE);
    end else if (pick < 66) begin
      src_bytes.push_back(OPS[$urandom_range(4)]);
      if ($urandom_range(1) == 1) src_bytes.push_back(slt_pkg::CH_EQ);
    end else if (pick < 72) begin
      src_bytes.push_back(slt_pkg::CH_SLASH);
      src_bytes.push_back(slt_pkg::CH_SLASH);
      repeat ($urandom_range(6)) begin
        c = 8'($urandom_range(255));
        src_bytes.push_back((c == slt_pkg::CH_NL) ? slt_pkg::CH_SPACE : c);
      end
      src_bytes.push_back(slt_pkg::CH_NL);
    end else if (pick < 84) begin
      src_bytes.push_back(PUNCT[$urandom_range(9)]);
    end else if (pick < 94) begin
      src_bytes.push_back(SPACES[$urandom_range(3)]);
    end else begin
      src_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  // One random source, ended either on its final character or by an
  // end-only word; empty words are scattered in
  task automatic send_source();
    bit tail_mark;
    src_bytes.delete();
    tail_mark = 1'($urandom_range(1));
    repeat ($urandom_range(2, 12)) add_fragment();
    foreach (src_bytes[i]) begin
      if ($urandom_range(19) == 0)
        send_char(stim_row_t'{8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0});
      send_char(stim_row_t'{src_bytes[i], 1'b1,
                            tail_mark && (i == src_bytes.size() - 1), 1'b0, '0});
    end
    if (!tail_mark)
      send_char(stim_row_t'{8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0});
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  // Check each token word against the oldest one due
  always @(posedge clk) begin : watch_tokens
    tok_t got;
    tok_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind   = out_tuser[5:0];
      got.err    = slt_pkg::err_t'(out_tuser[7:6]);
      got.lstart = out_tdata[15:0];
      got.lend   = out_tdata[31:16];
      got.line   = out_tdata[47:32];
      got.last   = out_tlast;
      if (tokens_due.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_SHOWN)
          $display("token with none outstanding: kind %0d err %0d span %0d..%0d line %0d",
                   got.kind, got.err, got.lstart, got.lend, got.line);
      end else begin
        want = tokens_due.pop_front();
        if (got !== want) begin
          bad_count++;
          if (bad_count <= MAX_SHOWN)
            $display("token mismatch: want kind %0d err %0d span %0d..%0d line %0d last %0b",
                     want.kind, want.err, want.lstart, want.lend, want.line, want.last,
                     " / got kind %0d err %0d span %0d..%0d line %0d last %0b",
                     got.kind, got.err, got.lstart, got.lend, got.line, got.last);
        end
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : run
    // directed source: errors, operators, comment, number then dot,
    // keyword, string, fraction, empty word, end mark
    dir_rows = '{
      '{8'h40,              1'b1, 1'b0, 1'b1,
        '{slt_pkg::TK_ERROR, slt_pkg::ERR_UNEXPECTED, 16'd0, 16'd1, 16'd1, 1'b1}},
      '{8'h00,              1'b1, 1'b0, 1'b1,
        '{slt_pkg::TK_ERROR, slt_pkg::ERR_UNEXPECTED, 16'd1, 16'd2, 16'd1, 1'b1}},
      '{8'hFF,              1'b1, 1'b0, 1'b1,
        '{slt_pkg::TK_ERROR, slt_pkg::ERR_UNEXPECTED, 16'd2, 16'd3, 16'd1, 1'b1}},
      '{slt_pkg::CH_NL,     1'b1, 1'b0, 1'b0, '0},
      '{slt_pkg::CH_LPAREN, 1'b1, 1'b0, 1'b0, '0},
      '{slt_pkg::CH_BANG,   1'b1, 1'b0, 1'b0, '0},
      '{slt_pkg::CH_EQ,     1'b1, 1'b0, 1'b0, '0},
      '{slt_pkg::CH_SLASH,  1'b1, 1'b0, 1'b0, '0},
      '{slt_pkg::CH_SLASH,  1'b1, 1'b0, 1'b0, '0},
      '{"x",                1'b1, 1'b0, 1'b0, '0},
      '{slt_pkg::CH_NL,     1'b1, 1'b0, 1'b0, '0},
      '{"1",                1'b1, 1'b0, 1'b0, '0},
      '{slt_pkg::CH_DOT,    1'b1, 1'b0, 1'b0, '0},
      '{"a",                1'b1, 1'b0, 1'b0, '0},
      '{"n",                1'b1, 1'b0, 1'b0, '0},
      '{"d",                1'b1, 1'b0, 1'b0, '0},
      '{slt_pkg::CH_SPACE,  1'b1, 1'b0, 1'b0, '0},
      '{slt_pkg::CH_QUOTE,  1'b1, 1'b0, 1'b0, '0},
      '{"q",                1'b1, 1'b0, 1'b0, '0},
      '{slt_pkg::CH_QUOTE,  1'b1, 1'b0, 1'b0, '0},
      '{"7",                1'b1, 1'b0, 1'b0, '0},
      '{slt_pkg::CH_DOT,    1'b1, 1'b0, 1'b0, '0},
      '{"5",                1'b1, 1'b0, 1'b0, '0},
      '{8'h00,              1'b0, 1'b0, 1'b0, '0},
      '{slt_pkg::CH_LT,     1'b1, 1'b1, 1'b0, '0},
      '{8'h00,              1'b0, 1'b1, 1'b1,
        '{slt_pkg::TK_EOF, slt_pkg::ERR_NONE, 16'd0, 16'd0, 16'd1, 1'b1}}
    };

    // hold reset, release it at a falling edge
    clear_scan();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_char(dir_rows[i]);

    // random sources: sender light, receiver heavy
    while (items_sent < 150) send_source();
    // swap the stall rates
    src_idle = 64;
    rcv_idle = 33;
    while (items_sent < 270) send_source();
    // no stalls
    src_idle = 0;
    rcv_idle = 0;
    while (items_sent < 390) send_source();
    in_tvalid <= 1'b0;

    // drain, then allow for stray words
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (bad_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/slt_pkg.sv
design/slt_kwmatch.sv
design/script_lexer_tokenizer.sv
verif/tb.sv
